FILE: hdl/tkt_pkg.sv
// ----------------------------------------------------------------------------
// tkt_pkg
// Shared types and constants for the track key table.
// ----------------------------------------------------------------------------
package tkt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_LOOKUP = 3'd2;
    localparam logic [2:0] OP_ACK    = 3'd3;
    localparam logic [2:0] OP_UNMARK = 3'd4;
    localparam logic [2:0] OP_SWEEP  = 3'd5;
    localparam logic [2:0] OP_TICK   = 3'd6;
    localparam logic [2:0] OP_CLEAR  = 3'd7;

    localparam logic signed [15:0] ORDER_NONE = -16'sd1;

    typedef struct packed {
        logic [7:0]         area;
        logic [7:0]         ident;
        logic [11:0]        track;
        logic               ack;
        logic signed [15:0] order;
        logic               mark;
        logic [31:0]        stamp;
    } entry_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  station_area;
        logic [7:0]  station_id;
        logic [11:0] track_number;
        logic        match_any_track;
        logic        has_order;
        logic [14:0] order_value;
        logic        ack_value;
    } cmd_t;

    typedef struct packed {
        logic               found;
        logic               table_full;
        logic [11:0]        found_track;
        logic               found_ack;
        logic signed [15:0] found_order;
        logic [15:0]        elapsed_seconds;
        logic [CNT_W-1:0]   entry_count;
    } result_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

endpackage

FILE: hdl/tkt_store.sv
// ----------------------------------------------------------------------------
// tkt_store
// Entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tkt_store (
    input  logic             clk,
    input  tkt_pkg::mem_req_t req,
    output tkt_pkg::entry_t   rdata
);

    tkt_pkg::entry_t mem [tkt_pkg::TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

FILE: hdl/tkt_seq.sv
// ----------------------------------------------------------------------------
// tkt_seq
// Sequencer: walks the entry memory one entry per read/evaluate pair for
// search, shift insert, close-up removal, unmark and sweep.
// ----------------------------------------------------------------------------
module tkt_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tkt_pkg::cmd_t     cmd,
    output logic              idle,
    input  logic              out_free,
    output logic              done,
    output tkt_pkg::result_t  result,
    output tkt_pkg::mem_req_t req,
    input  tkt_pkg::entry_t   rdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_EV, S_SHIFT_RD, S_SHIFT_EV,
        S_INS_WR, S_WALK_RD, S_WALK_EV, S_FINISH
    } state_t;

    state_t                      state_reg, state_next;
    tkt_pkg::cmd_t               cmd_reg, cmd_next;
    logic [tkt_pkg::CNT_W-1:0]   j_reg, j_next;
    logic [tkt_pkg::CNT_W-1:0]   k_reg, k_next;
    logic                        kset_reg, kset_next;
    logic                        up_reg, up_next;
    logic [tkt_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [31:0]                 now_reg, now_next;
    tkt_pkg::result_t            res_reg, res_next;

    tkt_pkg::entry_t             mod_e;
    tkt_pkg::entry_t             new_e;
    logic                        hit;
    logic [31:0]                 diff;
    logic [tkt_pkg::CNT_W-1:0]   jm1, jp1;

    assign idle   = (state_reg == S_IDLE);
    assign done   = (state_reg == S_FINISH) && out_free;
    assign jm1    = j_reg - 1'b1;
    assign jp1    = j_reg + 1'b1;

    always_comb
    begin
        result             = res_reg;
        result.entry_count = cnt_reg;
    end

    always_comb
    begin
        hit = (rdata.area == cmd_reg.station_area) && (rdata.ident == cmd_reg.station_id)
            && (cmd_reg.match_any_track || (rdata.track == cmd_reg.track_number));
        mod_e = rdata;
        if (cmd_reg.opcode == tkt_pkg::OP_ADD)
        begin
            mod_e.stamp = now_reg;
            mod_e.mark  = 1'b1;
        end
        else if (cmd_reg.opcode == tkt_pkg::OP_ACK)
        begin
            mod_e.ack = cmd_reg.ack_value;
        end
        diff = now_reg - mod_e.stamp;
        new_e.area  = cmd_reg.station_area;
        new_e.ident = cmd_reg.station_id;
        new_e.track = cmd_reg.track_number;
        new_e.ack   = 1'b0;
        new_e.order = cmd_reg.has_order ? $signed({1'b0, cmd_reg.order_value})
                                        : tkt_pkg::ORDER_NONE;
        new_e.mark  = 1'b1;
        new_e.stamp = now_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        kset_next  = kset_reg;
        up_next    = up_reg;
        cnt_next   = cnt_reg;
        now_next   = now_reg;
        res_next   = res_reg;
        req.we     = 1'b0;
        req.waddr  = j_reg[tkt_pkg::IDX_W-1:0];
        req.wdata  = rdata;
        req.raddr  = j_reg[tkt_pkg::IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = cmd;
                    j_next    = '0;
                    k_next    = '0;
                    kset_next = 1'b0;
                    res_next  = '0;
                    res_next.found_order = tkt_pkg::ORDER_NONE;
                    unique case (cmd.opcode) inside
                        tkt_pkg::OP_UNMARK, tkt_pkg::OP_SWEEP: state_next = S_WALK_RD;
                        tkt_pkg::OP_TICK:
                        begin
                            if (now_reg != 32'hFFFF_FFFF)
                            begin
                                now_next = now_reg + 32'd1;
                            end
                            state_next = S_FINISH;
                        end
                        tkt_pkg::OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = S_FINISH;
                        end
                        default: state_next = S_SCAN_RD;
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                if (j_reg == cnt_reg)
                begin
                    if (cmd_reg.opcode != tkt_pkg::OP_ADD)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (cnt_reg == tkt_pkg::CNT_W'(tkt_pkg::TABLE_DEPTH))
                    begin
                        res_next.table_full = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        if (!kset_reg)
                        begin
                            k_next = cnt_reg;
                        end
                        up_next = 1'b1;
                        state_next = (kset_reg && (k_reg != cnt_reg)) ? S_SHIFT_RD : S_INS_WR;
                    end
                end
                else
                begin
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                if (hit)
                begin
                    res_next.found       = 1'b1;
                    res_next.found_track = mod_e.track;
                    res_next.found_ack   = mod_e.ack;
                    res_next.found_order = mod_e.order;
                    res_next.elapsed_seconds = (|diff[31:16]) ? 16'hFFFF : diff[15:0];
                    req.we = (cmd_reg.opcode == tkt_pkg::OP_ADD)
                          || (cmd_reg.opcode == tkt_pkg::OP_ACK);
                    req.wdata = mod_e;
                    if (cmd_reg.opcode == tkt_pkg::OP_REMOVE)
                    begin
                        up_next = 1'b0;
                        if (jp1 == cnt_reg)
                        begin
                            cnt_next   = cnt_reg - 1'b1;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SHIFT_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    if (cmd_reg.has_order && !kset_reg
                        && ($signed({1'b0, cmd_reg.order_value}) < rdata.order))
                    begin
                        k_next    = j_reg;
                        kset_next = 1'b1;
                    end
                    j_next     = jp1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                req.raddr  = up_reg ? jm1[tkt_pkg::IDX_W-1:0] : jp1[tkt_pkg::IDX_W-1:0];
                state_next = S_SHIFT_EV;
            end
            S_SHIFT_EV:
            begin
                req.we = 1'b1;
                if (up_reg)
                begin
                    j_next     = jm1;
                    state_next = (jm1 == k_reg) ? S_INS_WR : S_SHIFT_RD;
                end
                else
                begin
                    j_next = jp1;
                    if ((jp1 + 1'b1) == cnt_reg)
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
            end
            S_INS_WR:
            begin
                req.we     = 1'b1;
                req.waddr  = k_reg[tkt_pkg::IDX_W-1:0];
                req.wdata  = new_e;
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_FINISH;
            end
            S_WALK_RD:
            begin
                if (j_reg == cnt_reg)
                begin
                    if (cmd_reg.opcode == tkt_pkg::OP_SWEEP)
                    begin
                        cnt_next = k_reg;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_WALK_EV;
                end
            end
            S_WALK_EV:
            begin
                if (cmd_reg.opcode == tkt_pkg::OP_UNMARK)
                begin
                    req.we = 1'b1;
                    req.wdata.mark = 1'b0;
                end
                else if (rdata.mark)
                begin
                    req.we    = 1'b1;
                    req.waddr = k_reg[tkt_pkg::IDX_W-1:0];
                    k_next    = k_reg + 1'b1;
                end
                j_next     = jp1;
                state_next = S_WALK_RD;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            now_reg   <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            kset_reg  <= 1'b0;
            up_reg    <= 1'b0;
            cmd_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            now_reg   <= now_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            kset_reg  <= kset_next;
            up_reg    <= up_next;
            cmd_reg   <= cmd_next;
            res_reg   <= res_next;
        end
    end

endmodule

FILE: hdl/track_key_table_core.sv
// ----------------------------------------------------------------------------
// track_key_table_core
// Ordered table of track keys with search, ordered insert and compaction.
// ----------------------------------------------------------------------------
// One word is taken when s_axis_tready is high, and the block stays busy
// until its result is loaded into the output register. The entry memory has
// a single registered read port, so a search reads and then evaluates each
// entry visited; moving an entry for an insert or a removal, or visiting one
// for an unmark or a sweep, also takes a read and an evaluate step. The worst
// case is an ordered insert at the front of a 31-entry table: it searches all
// 31 entries, shifts all 31 up, then writes the new entry and finishes. Tick
// and clear go straight to finish without visiting the memory. A finished
// result waits in the output register while the next word is accepted.
module track_key_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[2:0] station_area[10:3] station_id[18:11] track_number[30:19]
    // match_any_track[31] has_order[32] order_value[47:33] ack_value[48]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // found[0] table_full[1] found_track[13:2] found_ack[14]
    // found_order[30:15] elapsed_seconds[46:31] entry_count[52:47]
    output logic [55:0] m_axis_tdata
);

    tkt_pkg::cmd_t     cmd;
    tkt_pkg::result_t  result;
    tkt_pkg::mem_req_t req;
    tkt_pkg::entry_t   rdata;
    logic              idle, done, out_free;
    logic              out_valid_reg;
    tkt_pkg::result_t  out_data_reg;

    assign cmd.opcode          = s_axis_tdata[2:0];
    assign cmd.station_area    = s_axis_tdata[10:3];
    assign cmd.station_id      = s_axis_tdata[18:11];
    assign cmd.track_number    = s_axis_tdata[30:19];
    assign cmd.match_any_track = s_axis_tdata[31];
    assign cmd.has_order       = s_axis_tdata[32];
    assign cmd.order_value     = s_axis_tdata[47:33];
    assign cmd.ack_value       = s_axis_tdata[48];

    assign s_axis_tready = idle;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_data_reg.entry_count, out_data_reg.elapsed_seconds,
                            out_data_reg.found_order, out_data_reg.found_ack,
                            out_data_reg.found_track, out_data_reg.table_full,
                            out_data_reg.found};

    tkt_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (s_axis_tvalid && idle),
        .cmd      (cmd),
        .idle     (idle),
        .out_free (out_free),
        .done     (done),
        .result   (result),
        .req      (req),
        .rdata    (rdata)
    );

    tkt_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_data_reg <= result;
        end
    end

endmodule

FILE: hdl/tkt_checker.sv
// ----------------------------------------------------------------------------
// tkt_checker
// Port-level checks for the track key table, bound to the top level.
// ----------------------------------------------------------------------------
module tkt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [55:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted a word while busy");

    a_full_nf: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("full and found both set");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[52:47] <= 6'd32)
        else $error("entry count out of range");

    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[46:2] == {16'd0, 16'hFFFF, 13'd0})
        else $error("miss fields not at defaults");

endmodule

bind track_key_table_core tkt_checker u_tkt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
